>>> hdl/sgr_pkg.sv
// Shared types, constants and helpers for the SGR text styler.
package sgr_pkg;

   localparam int MAX_PARAMS_DEF  = 16;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [7:0] ESC_CHAR   = 8'h1B;
   localparam logic [7:0] LBRACKET   = 8'h5B;
   localparam logic [7:0] SEMI_CHAR  = 8'h3B;
   localparam logic [7:0] M_CHAR     = 8'h6D;
   localparam logic [7:0] DIGIT_ZERO = 8'h30;
   localparam logic [7:0] DIGIT_NINE = 8'h39;

   localparam logic [15:0] SGR_RESET    = 16'd0;
   localparam logic [15:0] SGR_BOLD     = 16'd1;
   localparam logic [15:0] SGR_DIM      = 16'd2;
   localparam logic [15:0] SGR_ITALIC   = 16'd3;
   localparam logic [15:0] SGR_NORMAL   = 16'd22;
   localparam logic [15:0] SGR_NO_ITAL  = 16'd23;
   localparam logic [15:0] SGR_FG_FIRST = 16'd30;
   localparam logic [15:0] SGR_FG_LAST  = 16'd35;
   localparam logic [15:0] SGR_FG_EXT   = 16'd38;
   localparam logic [15:0] SGR_FG_DEF   = 16'd39;
   localparam logic [15:0] SGR_BG_EXT   = 16'd48;
   localparam logic [15:0] SGR_SUB_RGB  = 16'd2;
   localparam logic [15:0] SGR_SUB_IDX  = 16'd5;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_EOL  = 1'b1;

   typedef enum logic [1:0] {
      MODE_TEXT = 2'd0,
      MODE_ESC  = 2'd1,
      MODE_CSI  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      B_IDLE, B_FETCH, B_CODE, B_SUB, B_RED, B_GRN, B_BLU, B_EMIT
   } back_state_type;

   // One queue word: the actions that one input byte causes, in order.
   typedef struct packed {
      logic        clear;
      logic        push;
      logic [15:0] val;
      logic        apply;
      logic        esc1;
      logic        chr;
      logic [7:0]  ch;
      logic        esc2;
      logic        eol;
      logic [23:0] def;
   } cmd_type;

   function automatic logic [23:0] basic_color(input logic [2:0] idx);
      case (idx)
         3'd0:    basic_color = 24'h000000;
         3'd1:    basic_color = 24'hD26464;
         3'd2:    basic_color = 24'h5AC86E;
         3'd3:    basic_color = 24'hDCBE64;
         3'd4:    basic_color = 24'h8CAAD2;
         3'd5:    basic_color = 24'hBEA0E6;
         default: basic_color = 24'h000000;
      endcase
   endfunction

endpackage

>>> hdl/sgr_ifs.sv
// Channel interfaces for the SGR text styler.
interface sgr_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  byte_req;
   logic [23:0] default_color;
   logic        line_end;
   modport source (output valid, byte_req, default_color, line_end, input ready);
   modport sink (input valid, byte_req, default_color, line_end, output ready);
endinterface

interface sgr_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  ch;
   logic [23:0] fg_color;
   logic        bold;
   logic        italic;
   logic        dim;
   logic        last;
   modport source (output valid, kind, ch, fg_color, bold, italic, dim, last,
                   input ready);
   modport sink (input valid, kind, ch, fg_color, bold, italic, dim, last,
                 output ready);
endinterface

>>> hdl/sgr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sgr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> hdl/sgr_fifo.sv
// Short command queue between the parser front and the style back end.
module sgr_fifo import sgr_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_word,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_word,
   output logic    empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type        slot_ff [DEPTH];
   logic [PW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]  cnt_ff, cnt_in;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_word = slot_ff[rd_ff];

   // Pointer and fill count update with wraparound at any depth.
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_word;
      end
   end
endmodule

>>> hdl/sgr_front.sv
// Parser front: tracks escape mode and numbers, turns each byte into a command word.
module sgr_front import sgr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   sgr_req_if.sink req_in,
   input  logic    q_full,
   output logic    q_push,
   output cmd_type q_word
);
   mode_type    mode_ff, mode_in;
   logic [15:0] acc_ff, acc_in;
   logic        seen_ff, seen_in;
   logic [7:0]  b;
   logic [19:0] prod;
   logic        is_digit;

   assign req_in.ready = !q_full;
   assign q_push       = req_in.valid && !q_full;
   assign b            = req_in.byte_req;
   assign is_digit     = (b >= DIGIT_ZERO) && (b <= DIGIT_NINE);
   assign prod         = {4'b0, acc_ff} * 20'd10 + {12'b0, b - DIGIT_ZERO};

   // Classify the byte and build its command word.
   always_comb begin
      mode_in = mode_ff;
      acc_in  = acc_ff;
      seen_in = seen_ff;
      q_word  = '0;
      q_word.ch  = b;
      q_word.val = acc_ff;
      q_word.def = req_in.default_color;
      unique case (mode_ff)
         MODE_ESC: begin
            if (b == LBRACKET) begin
               q_word.clear = 1'b1;
               mode_in = MODE_CSI;
               acc_in  = '0;
               seen_in = 1'b0;
            end else begin
               q_word.esc1 = 1'b1;
               if (b == ESC_CHAR) begin
                  mode_in = MODE_ESC;
               end else begin
                  q_word.chr = 1'b1;
                  mode_in = MODE_TEXT;
               end
            end
         end
         MODE_CSI: begin
            if (is_digit) begin
               acc_in  = (prod > 20'd65535) ? 16'hFFFF : prod[15:0];
               seen_in = 1'b1;
            end else if (b == SEMI_CHAR) begin
               q_word.push = 1'b1;
               acc_in  = '0;
               seen_in = 1'b0;
            end else begin
               if (b == M_CHAR) begin
                  q_word.push  = seen_ff;
                  q_word.apply = 1'b1;
               end
               mode_in = MODE_TEXT;
            end
         end
         default: begin
            if (b == ESC_CHAR) begin
               mode_in = MODE_ESC;
            end else begin
               q_word.chr = 1'b1;
               mode_in = MODE_TEXT;
            end
         end
      endcase
      // End of line flushes a pending ESC and resets the parser.
      if (req_in.line_end) begin
         q_word.esc2 = (mode_in == MODE_ESC);
         q_word.eol  = 1'b1;
         mode_in = MODE_TEXT;
         acc_in  = '0;
         seen_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TEXT;
         acc_ff  <= '0;
         seen_ff <= 1'b0;
      end else if (q_push) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         seen_ff <= seen_in;
      end
   end
endmodule

>>> hdl/sgr_back.sv
// Style back end: buffers parameters, walks them on apply and emits styled words.
module sgr_back import sgr_pkg::*; #(
   parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  cmd_type     q_word,
   output logic        q_pop,
   sgr_rsp_if.source   rsp_out
);
   localparam int AW = $clog2(MAX_PARAMS);
   localparam int CW = $clog2(MAX_PARAMS + 5);

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff, cmd_in;
   logic [CW-1:0]  cnt_ff, cnt_in, k_ff, k_in;
   logic [23:0]    color_ff, color_in;
   logic           cdef_ff, cdef_in;
   logic           bold_ff, bold_in, ital_ff, ital_in, dim_ff, dim_in;
   logic           is38_ff, is38_in;
   logic [7:0]     red_ff, red_in, grn_ff, grn_in;
   logic [AW-1:0]  rd_addr;
   logic [15:0]    rd_data;
   logic           ram_we;
   logic           ov_ff, ov_in;
   logic           o_kind_ff, o_kind_in, o_last_ff, o_last_in;
   logic [7:0]     o_ch_ff, o_ch_in;
   logic [23:0]    o_col_ff, o_col_in;
   logic [2:0]     o_flg_ff, o_flg_in;
   logic           slot_free;
   logic [15:0]    p;
   logic [CW-1:0]  k1, k2, k3, k4;

   assign ram_we = q_pop && q_word.push && (cnt_ff < CW'(MAX_PARAMS))
                   && !q_word.clear;

   sgr_ram #(.WIDTH(16), .DEPTH(MAX_PARAMS)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (cnt_ff[AW-1:0]),
      .wdata (q_word.val),
      .raddr (rd_addr),
      .rdata (rd_data)
   );

   assign slot_free = !ov_ff || rsp_out.ready;
   assign p  = rd_data;
   assign k1 = k_ff + CW'(1);
   assign k2 = k_ff + CW'(2);
   assign k3 = k_ff + CW'(3);
   assign k4 = k_ff + CW'(4);

   // Sequencer: take a command, walk parameters, then emit its words.
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      color_in = color_ff;
      cdef_in  = cdef_ff;
      bold_in  = bold_ff;
      ital_in  = ital_ff;
      dim_in   = dim_ff;
      is38_in  = is38_ff;
      red_in   = red_ff;
      grn_in   = grn_ff;
      rd_addr  = k_ff[AW-1:0];
      q_pop    = 1'b0;
      ov_in     = ov_ff && !rsp_out.ready;
      o_kind_in = o_kind_ff;
      o_last_in = o_last_ff;
      o_ch_in   = o_ch_ff;
      o_col_in  = o_col_ff;
      o_flg_in  = o_flg_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cmd_in = q_word;
               if (q_word.clear) begin
                  cnt_in = '0;
               end else if (q_word.push && (cnt_ff < CW'(MAX_PARAMS))) begin
                  cnt_in = cnt_ff + CW'(1);
               end
               k_in = '0;
               if (q_word.apply) begin
                  if (cnt_in == '0) begin
                     cdef_in  = 1'b1;
                     bold_in  = 1'b0;
                     ital_in  = 1'b0;
                     dim_in   = 1'b0;
                     state_in = B_EMIT;
                  end else begin
                     state_in = B_FETCH;
                  end
               end else begin
                  state_in = B_EMIT;
               end
            end
         end
         B_FETCH: begin
            rd_addr  = k_ff[AW-1:0];
            state_in = (k_ff < cnt_ff) ? B_CODE : B_EMIT;
         end
         B_CODE: begin
            rd_addr  = k1[AW-1:0];
            state_in = B_FETCH;
            k_in     = k1;
            if (p == SGR_RESET) begin
               cdef_in = 1'b1;
               bold_in = 1'b0;
               ital_in = 1'b0;
               dim_in  = 1'b0;
            end else if (p == SGR_BOLD) begin
               bold_in = 1'b1;
            end else if (p == SGR_DIM) begin
               dim_in = 1'b1;
            end else if (p == SGR_ITALIC) begin
               ital_in = 1'b1;
            end else if (p == SGR_NORMAL) begin
               bold_in = 1'b0;
               dim_in  = 1'b0;
            end else if (p == SGR_NO_ITAL) begin
               ital_in = 1'b0;
            end else if (p >= SGR_FG_FIRST && p <= SGR_FG_LAST) begin
               color_in = basic_color(3'(p - SGR_FG_FIRST));
               cdef_in  = 1'b0;
            end else if (p == SGR_FG_DEF) begin
               cdef_in = 1'b1;
            end else if ((p == SGR_FG_EXT || p == SGR_BG_EXT) && (k2 < cnt_ff)) begin
               is38_in  = (p == SGR_FG_EXT);
               k_in     = k_ff;
               state_in = B_SUB;
            end
         end
         B_SUB: begin
            rd_addr  = k2[AW-1:0];
            state_in = B_FETCH;
            if (p == SGR_SUB_RGB && (k4 < cnt_ff)) begin
               state_in = B_RED;
            end else if (p == SGR_SUB_IDX) begin
               k_in = k3;
            end else begin
               k_in = k1;
            end
         end
         B_RED: begin
            rd_addr  = k3[AW-1:0];
            red_in   = p[7:0];
            state_in = B_GRN;
         end
         B_GRN: begin
            rd_addr  = k4[AW-1:0];
            grn_in   = p[7:0];
            state_in = B_BLU;
         end
         B_BLU: begin
            if (is38_ff) begin
               color_in = {red_ff, grn_ff, p[7:0]};
               cdef_in  = 1'b0;
            end
            k_in     = k_ff + CW'(5);
            state_in = B_FETCH;
         end
         B_EMIT: begin
            if (!(cmd_ff.esc1 || cmd_ff.chr || cmd_ff.esc2 || cmd_ff.eol)) begin
               state_in = B_IDLE;
            end else if (slot_free) begin
               ov_in     = 1'b1;
               o_kind_in = KIND_CHAR;
               o_col_in  = cdef_ff ? cmd_ff.def : color_ff;
               o_flg_in  = {dim_ff, ital_ff, bold_ff};
               if (cmd_ff.esc1) begin
                  o_ch_in     = ESC_CHAR;
                  cmd_in.esc1 = 1'b0;
                  o_last_in   = !(cmd_ff.chr || cmd_ff.esc2 || cmd_ff.eol);
               end else if (cmd_ff.chr) begin
                  o_ch_in    = cmd_ff.ch;
                  cmd_in.chr = 1'b0;
                  o_last_in  = !(cmd_ff.esc2 || cmd_ff.eol);
               end else if (cmd_ff.esc2) begin
                  o_ch_in     = ESC_CHAR;
                  cmd_in.esc2 = 1'b0;
                  o_last_in   = !cmd_ff.eol;
               end else begin
                  // End of line marker; the style returns to its reset values.
                  o_kind_in  = KIND_EOL;
                  o_ch_in    = '0;
                  o_col_in   = '0;
                  o_flg_in   = '0;
                  o_last_in  = 1'b1;
                  cmd_in.eol = 1'b0;
                  cnt_in     = '0;
                  color_in   = '0;
                  cdef_in    = 1'b1;
                  bold_in    = 1'b0;
                  ital_in    = 1'b0;
                  dim_in     = 1'b0;
               end
               // The last word of this command returns the sequencer to idle.
               if (o_last_in) begin
                  state_in = B_IDLE;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         cnt_ff   <= '0;
         color_ff <= '0;
         cdef_ff  <= 1'b1;
         bold_ff  <= 1'b0;
         ital_ff  <= 1'b0;
         dim_ff   <= 1'b0;
         ov_ff    <= 1'b0;
         cmd_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         color_ff <= color_in;
         cdef_ff  <= cdef_in;
         bold_ff  <= bold_in;
         ital_ff  <= ital_in;
         dim_ff   <= dim_in;
         ov_ff    <= ov_in;
         cmd_ff   <= cmd_in;
      end
      k_ff      <= k_in;
      is38_ff   <= is38_in;
      red_ff    <= red_in;
      grn_ff    <= grn_in;
      o_kind_ff <= o_kind_in;
      o_last_ff <= o_last_in;
      o_ch_ff   <= o_ch_in;
      o_col_ff  <= o_col_in;
      o_flg_ff  <= o_flg_in;
   end

   assign rsp_out.valid    = ov_ff;
   assign rsp_out.kind     = o_kind_ff;
   assign rsp_out.ch       = o_ch_ff;
   assign rsp_out.fg_color = o_col_ff;
   assign rsp_out.bold     = o_flg_ff[0];
   assign rsp_out.italic   = o_flg_ff[1];
   assign rsp_out.dim      = o_flg_ff[2];
   assign rsp_out.last     = o_last_ff;
endmodule

>>> hdl/ansi_sgr_text_styler_top.sv
// Top level of the ANSI SGR text styler.
// The styler takes one byte per word and strips CSI escapes, giving each visible byte
// with its color and bold, italic and dim flags, and an end of line marker after the
// byte flagged line_end. The front parser accepts a word per cycle while its command
// queue has room. For each byte the back end first takes its command, then emits its
// words or, for a byte that gives no word, returns to idle. A terminating 'm' adds a
// walk of the parameter store through its registered read port, stepping over single
// codes and whole 38;5;n, 48;5;n, 38;2;r;g;b and 48;2;r;g;b forms. A word that the
// receiver holds back stalls the back end; the front stalls once the queue is full.
module ansi_sgr_text_styler_top import sgr_pkg::*; #(
   parameter int MAX_PARAMS  = MAX_PARAMS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   sgr_req_if.sink    req_in,
   sgr_rsp_if.source  rsp_out
);
   logic    q_full, q_push, q_empty, q_pop;
   cmd_type q_in_word, q_out_word;

   sgr_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_in (req_in),
      .q_full (q_full),
      .q_push (q_push),
      .q_word (q_in_word)
   );

   sgr_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (q_in_word),
      .full      (q_full),
      .pop       (q_pop),
      .pop_word  (q_out_word),
      .empty     (q_empty)
   );

   sgr_back #(.MAX_PARAMS(MAX_PARAMS)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_word  (q_out_word),
      .q_pop   (q_pop),
      .rsp_out (rsp_out)
   );
endmodule
